@@ hdl/fea_pkg.sv @@
// Shared widths, reset values, register indexes and the pixel type for the fire-effect neighbour average.
package fea_pkg;

  localparam int PIX_W = 8;
  localparam int POS_W = 10;
  localparam int CFG_W = 11;
  localparam int SUM_W = PIX_W + 3;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(320);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(240);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } fea_reg_idx_t;

  typedef logic [PIX_W-1:0] fea_pix_t;

endpackage

@@ hdl/fea_line_mem.sv @@
// Line memory holding the two previous rows per column, with write-to-read forwarding.
module fea_line_mem
  import fea_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [2*PIX_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [2*PIX_W-1:0] wr_data
);

  // Each entry holds {row one back, row two back} for one column.
  logic [2*PIX_W-1:0] mem [DEPTH];
  logic [2*PIX_W-1:0] mem_q_r;
  logic [2*PIX_W-1:0] fwd_q_r;
  logic               fwd_hit_r;
  logic               fwd_hit_nxt;

  assign fwd_hit_nxt = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      fwd_q_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= fwd_hit_nxt;
    end
  end

  // A read that met a write to the same column in the same cycle sees the new word.
  assign rd_data = fwd_hit_r ? fwd_q_r : mem_q_r;

endmodule

@@ hdl/fire_effect_neighbor_average_core.sv @@
// Top level of the fire-effect eight-neighbour average filter.
// The block takes one pixel per clock while its compute stage is not stalled and
// gives at most one filtered pixel per pixel taken; the pixel waits in the compute
// stage and its result in the output register. The line memory reads at the
// arriving pixel's column when a pixel is taken and writes back the word in the
// compute stage when it moves on; a write and a read of the same column in one
// cycle are forwarded. While a result waits on a stalled output, pixels that give
// no result still flow through, and the next pixel that does give one is taken
// and held in the compute stage. No clearing pass follows reset: the line memory
// holds meaningful data once the first two rows of a frame have passed.
module fire_effect_neighbor_average_core
  import fea_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,    // [7:0] pixel_in
  input  logic                   in_tuser,    // [0] start_of_frame
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [7:0] pixel_out, [17:8] out_column,
                                              // [27:18] out_row, [31:28] zero
  input  logic                   cfg_wr_en,
  input  logic [0:0]             cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wr_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
  localparam int HW  = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);
  localparam logic [WW-1:0] MAX_W_C   = WW'(MAX_WIDTH);
  localparam logic [HW-1:0] MAX_H_C   = HW'(MAX_HEIGHT);
  localparam logic [RW-1:0] ROW_LAST  = RW'(MAX_HEIGHT - 1);
  localparam int PAD_W = OUT_TDATA_W - PIX_W - 2 * POS_W;

  // Configuration registers.
  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr_en) begin
      unique case (fea_reg_idx_t'(cfg_addr))
        REG_FRAME_WIDTH:  width_nxt  = cfg_wr_data;
        REG_FRAME_HEIGHT: height_nxt = cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  assign w_eff = (WW'(width_r) < MAX_W_C) ? WW'(width_r) : MAX_W_C;
  assign h_eff = (HW'(height_r) < MAX_H_C) ? HW'(height_r) : MAX_H_C;

  // Position of the arriving word.
  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [RW-1:0] row_r, row_nxt, row_cur;
  logic          in_acc;
  logic          s1_fire;
  logic          cur_emit;

  assign in_acc  = in_tvalid && in_tready;
  assign col_cur = in_tuser ? '0 : col_r;
  assign row_cur = in_tuser ? '0 : row_r;

  assign cur_emit = (WW'(col_cur) >= WW'(2)) && (WW'(col_cur) < w_eff) &&
                    (HW'(row_cur) >= HW'(3)) && (HW'(row_cur) < h_eff);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if ((WW'(col_cur) + WW'(1)) >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_cur < ROW_LAST) ? row_cur + RW'(1) : row_cur;
      end else begin
        col_nxt = col_cur + CW'(1);
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Compute stage: holds the accepted word while the memory read completes.
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_emit_r;
  logic          s1_first_r;
  fea_pix_t      s1_pix_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_emit_r  <= cur_emit;
      s1_first_r <= (col_cur == CW'(2));
      s1_pix_r   <= in_tdata;
      s1_col_r   <= col_cur;
      s1_row_r   <= row_cur;
    end
  end

  logic out_valid_r, out_valid_nxt;

  assign s1_fire      = s1_valid_r && (!s1_emit_r || !out_valid_r || out_tready);
  assign in_tready    = !s1_valid_r || s1_fire;
  assign s1_valid_nxt = in_acc ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  logic [2*PIX_W-1:0] rd_data;
  fea_pix_t           top_right;
  fea_pix_t           mid_right;

  fea_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (col_cur),
    .rd_data (rd_data),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data ({s1_pix_r, mid_right})
  );

  assign top_right = rd_data[PIX_W-1:0];
  assign mid_right = rd_data[2*PIX_W-1:PIX_W];

  // Column window: pairs hold columns c-1 and c-2 of top, middle and bottom rows.
  fea_pix_t win_r [6];
  fea_pix_t win_nxt [6];
  fea_pix_t prev_r, prev_nxt;
  fea_pix_t left;
  logic [SUM_W-1:0] sum;
  fea_pix_t result;

  assign left = s1_first_r ? win_r[1] : prev_r;
  assign sum  = SUM_W'(left) + SUM_W'(win_r[0]) + SUM_W'(top_right) +
                SUM_W'(win_r[3]) + SUM_W'(mid_right) + SUM_W'(win_r[5]) +
                SUM_W'(win_r[4]) + SUM_W'(s1_pix_r);
  assign result = sum[SUM_W-1:3];

  always_comb begin
    win_nxt  = win_r;
    prev_nxt = prev_r;
    if (s1_fire) begin
      win_nxt[1] = win_r[0];
      win_nxt[0] = top_right;
      win_nxt[3] = win_r[2];
      win_nxt[2] = mid_right;
      win_nxt[5] = win_r[4];
      win_nxt[4] = s1_pix_r;
      if (s1_emit_r) begin
        prev_nxt = result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
      prev_r <= '0;
    end else begin
      win_r  <= win_nxt;
      prev_r <= prev_nxt;
    end
  end

  // Output register.
  logic [CW-1:0]    col_m1;
  logic [RW-1:0]    row_m2;
  fea_pix_t         out_pix_r;
  logic [POS_W-1:0] out_col_r;
  logic [POS_W-1:0] out_row_r;

  assign col_m1 = s1_col_r - CW'(1);
  assign row_m2 = s1_row_r - RW'(2);

  assign out_valid_nxt = (s1_fire && s1_emit_r) ? 1'b1 :
                         (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit_r) begin
      out_pix_r <= result;
      out_col_r <= POS_W'(col_m1);
      out_row_r <= POS_W'(row_m2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_row_r, out_col_r, out_pix_r};

  // A stalled compute stage keeps its word and lets nothing in.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_pix_r))
    else $error("compute stage lost its word while stalled");

  // Every emitted result reaches the output register.
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_emit_r |=> out_valid_r)
    else $error("result dropped on the way to the output");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(s1_fire && s1_emit_r))
    else $error("waiting result overwritten");

  // An emitting word always lies inside the interior.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_emit_r |-> (s1_col_r >= CW'(2)) && (s1_row_r >= RW'(3)))
    else $error("emitting word outside the interior");

endmodule
